>>> rtl/core/ufe_pkg.sv
// ----------------------------------------------------------------------------
// ufe_pkg
// Shared types and constants of the union-find engine: field widths,
// operation codes, rank limit and the sequencer state type.
// ----------------------------------------------------------------------------
package ufe_pkg;

    // field widths
    localparam int ElemW = 10;
    localparam int EiuW  = 11;
    localparam int FuncW = 2;
    localparam int RankW = 4;

    // default store depth
    localparam int MaxElementsDef = 1024;

    // register reset and rank saturation
    localparam logic [EiuW-1:0]  EiuReset = 11'd1024;
    localparam logic [RankW-1:0] RankMax  = 4'd15;

    // operation codes
    typedef enum logic [FuncW-1:0] {
        FN_MAKESET = 2'd0,
        FN_FIND    = 2'd1,
        FN_UNION   = 2'd2
    } t_func;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_CMP_WR,
        ST_RANK_A,
        ST_RANK_B,
        ST_LINK,
        ST_OUT
    } t_state;

endpackage

>>> rtl/core/ufe_ram.sv
// ----------------------------------------------------------------------------
// ufe_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read (old data on a same-address write).
// ----------------------------------------------------------------------------
module ufe_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wen,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_ren,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ren) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/union_find_engine_unit.sv
// ----------------------------------------------------------------------------
// union_find_engine_unit
// Disjoint-set forest with union by rank and path compression, kept in a
// parent RAM and a rank RAM and driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
//  channel    | direction | signals                          | content
//  -----------+-----------+----------------------------------+--------------------
//  request    | in        | i_s_tvalid o_s_tready tdata tuser | func, elem_a, elem_b
//  result     | out       | o_m_tvalid i_m_tready tdata tuser | root, error
//  config     | in        | i_cfg_wen i_cfg_wdata            | elements_in_use
//
//  Makeset and rejected requests go from the accept straight to ST_OUT, from
//  which the result moves into the output register. A find over a path of L
//  links makes L+1 parent RAM reads to the root, then L read-write steps of
//  compression on the same RAM port pair. A union walks both paths with a
//  restart state between, then, unless the roots match, reads ranks and links.
//  One request is in flight at a time; the next is taken once the result sits
//  in the output register. Reset is synchronous, no clearing pass: entries are
//  defined by makeset. A stalled result holds the sequencer in its last state.
// ----------------------------------------------------------------------------
module union_find_engine_unit
    import ufe_pkg::*;
#(
    parameter int MAX_ELEMENTS = MaxElementsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [23:0]      i_s_tdata,   // [9:0] elem_a, [19:10] elem_b, zero pad
    input  logic [FuncW-1:0] i_s_tuser,   // [1:0] func
    // result channel
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [15:0]      o_m_tdata,   // [9:0] root, zero pad
    output logic             o_m_tuser,   // [0] error
    // configuration
    input  logic             i_cfg_wen,
    input  logic [EiuW-1:0]  i_cfg_wdata
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int SW = $clog2(MAX_ELEMENTS + 1);

    // state and payload registers
    t_state             r_state, n_state;
    logic [EiuW-1:0]    r_eiu;
    t_func              r_func, n_func;
    logic               r_phase_b, n_phase_b;
    logic [ElemW-1:0]   r_b, n_b;
    logic [ElemW-1:0]   r_x, n_x;
    logic [ElemW-1:0]   r_cur, n_cur;
    logic [ElemW-1:0]   r_root, n_root;
    logic [ElemW-1:0]   r_ra, n_ra;
    logic [ElemW-1:0]   r_rb, n_rb;
    logic [RankW-1:0]   r_rank_a, n_rank_a;
    logic [SW-1:0]      r_steps, n_steps;
    logic [ElemW-1:0]   r_res_root, n_res_root;
    logic               r_res_err, n_res_err;
    logic               r_out_valid, n_out_valid;
    logic [ElemW-1:0]   r_out_root, n_out_root;
    logic               r_out_err, n_out_err;

    // memory ports
    logic               w_par_wen, w_par_ren;
    logic [AW-1:0]      w_par_waddr, w_par_raddr;
    logic [ElemW-1:0]   w_par_wdata, w_par_rdata;
    logic               w_rank_wen, w_rank_ren;
    logic [AW-1:0]      w_rank_waddr, w_rank_raddr;
    logic [RankW-1:0]   w_rank_wdata, w_rank_rdata;

    // decode of the incoming request
    logic               w_s_fire;
    logic [ElemW-1:0]   w_in_a, w_in_b;
    logic               w_ok_a, w_ok_b;
    logic [SW-1:0]      w_steps_inc;
    logic               w_bound;
    logic               w_p_root, w_p_stale;
    logic               w_fd;
    logic [ElemW-1:0]   w_fd_root;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_s_fire   = i_s_tvalid && o_s_tready;
    assign w_in_a     = i_s_tdata[ElemW-1:0];
    assign w_in_b     = i_s_tdata[2*ElemW-1:ElemW];
    assign w_ok_a     = ({1'b0, w_in_a} < r_eiu) && (32'(w_in_a) < 32'(MAX_ELEMENTS));
    assign w_ok_b     = ({1'b0, w_in_b} < r_eiu) && (32'(w_in_b) < 32'(MAX_ELEMENTS));

    // walk step count and stale-pointer check on the parent read data
    assign w_steps_inc = r_steps + SW'(1);
    assign w_bound     = (w_steps_inc == SW'(MAX_ELEMENTS));
    assign w_p_stale   = (32'(w_par_rdata) >= 32'(MAX_ELEMENTS));
    assign w_p_root    = (w_par_rdata == r_cur) || w_p_stale;

    // parent and rank stores
    ufe_ram #(.WIDTH(ElemW), .DEPTH(MAX_ELEMENTS)) u_parent_ram (
        .i_clk   (i_clk),
        .i_wen   (w_par_wen),
        .i_waddr (w_par_waddr),
        .i_wdata (w_par_wdata),
        .i_ren   (w_par_ren),
        .i_raddr (w_par_raddr),
        .o_rdata (w_par_rdata)
    );

    ufe_ram #(.WIDTH(RankW), .DEPTH(MAX_ELEMENTS)) u_rank_ram (
        .i_clk   (i_clk),
        .i_wen   (w_rank_wen),
        .i_waddr (w_rank_waddr),
        .i_wdata (w_rank_wdata),
        .i_ren   (w_rank_ren),
        .i_raddr (w_rank_raddr),
        .o_rdata (w_rank_rdata)
    );

    // sequencer: next state, memory accesses and result
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_phase_b   = r_phase_b;
        n_b         = r_b;
        n_x         = r_x;
        n_cur       = r_cur;
        n_root      = r_root;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_rank_a    = r_rank_a;
        n_steps     = r_steps;
        n_res_root  = r_res_root;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid;
        n_out_root  = r_out_root;
        n_out_err   = r_out_err;
        w_par_wen    = 1'b0;
        w_par_waddr  = '0;
        w_par_wdata  = '0;
        w_par_ren    = 1'b0;
        w_par_raddr  = '0;
        w_rank_wen   = 1'b0;
        w_rank_waddr = '0;
        w_rank_wdata = '0;
        w_rank_ren   = 1'b0;
        w_rank_raddr = '0;
        w_fd         = 1'b0;
        w_fd_root    = r_root;

        // result taken downstream
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_s_fire) begin
                    n_func     = t_func'(i_s_tuser);
                    n_b        = w_in_b;
                    n_x        = w_in_a;
                    n_cur      = w_in_a;
                    n_steps    = '0;
                    n_phase_b  = 1'b0;
                    n_res_root = '0;
                    n_res_err  = 1'b1;
                    n_state    = ST_OUT;
                    case (t_func'(i_s_tuser))
                        FN_MAKESET: begin
                            if (w_ok_a) begin
                                w_par_wen    = 1'b1;
                                w_par_waddr  = AW'(w_in_a);
                                w_par_wdata  = w_in_a;
                                w_rank_wen   = 1'b1;
                                w_rank_waddr = AW'(w_in_a);
                                w_rank_wdata = '0;
                                n_res_root   = w_in_a;
                                n_res_err    = 1'b0;
                            end
                        end
                        FN_FIND: begin
                            if (w_ok_a) begin
                                w_par_ren   = 1'b1;
                                w_par_raddr = AW'(w_in_a);
                                n_state     = ST_WALK_CHK;
                            end
                        end
                        FN_UNION: begin
                            if (w_ok_a && w_ok_b) begin
                                w_par_ren   = 1'b1;
                                w_par_raddr = AW'(w_in_a);
                                n_state     = ST_WALK_CHK;
                            end
                        end
                        default: begin
                            n_res_err = 1'b1;
                        end
                    endcase
                end
            end

            // start the walk of the second union operand
            ST_WALK_RD: begin
                w_par_ren   = 1'b1;
                w_par_raddr = AW'(r_cur);
                n_state     = ST_WALK_CHK;
            end

            // follow parent pointers up to the root
            ST_WALK_CHK: begin
                if (w_p_root || w_bound) begin
                    n_root = w_p_root ? r_cur : w_par_rdata;
                    if (r_x == n_root) begin
                        w_fd      = 1'b1;
                        w_fd_root = n_root;
                    end else begin
                        // compression restarts at the walked element
                        w_par_ren   = 1'b1;
                        w_par_raddr = AW'(r_x);
                        n_cur       = r_x;
                        n_steps     = '0;
                        n_state     = ST_CMP_WR;
                    end
                end else begin
                    w_par_ren   = 1'b1;
                    w_par_raddr = AW'(w_par_rdata);
                    n_cur       = w_par_rdata;
                    n_steps     = w_steps_inc;
                end
            end

            // point each node on the path at the root
            ST_CMP_WR: begin
                w_par_wen   = 1'b1;
                w_par_waddr = AW'(r_cur);
                w_par_wdata = r_root;
                n_cur       = w_par_rdata;
                n_steps     = w_steps_inc;
                if ((w_par_rdata != r_root) && !w_p_stale && !w_bound) begin
                    w_par_ren   = 1'b1;
                    w_par_raddr = AW'(w_par_rdata);
                end else begin
                    w_fd      = 1'b1;
                    w_fd_root = r_root;
                end
            end

            ST_RANK_A: begin
                w_rank_ren   = 1'b1;
                w_rank_raddr = AW'(r_ra);
                n_state      = ST_RANK_B;
            end

            ST_RANK_B: begin
                n_rank_a     = w_rank_rdata;
                w_rank_ren   = 1'b1;
                w_rank_raddr = AW'(r_rb);
                n_state      = ST_LINK;
            end

            // link the lower-ranked root under the other; on a tie the second root wins
            ST_LINK: begin
                w_par_wen = 1'b1;
                n_res_err = 1'b0;
                if (r_rank_a > w_rank_rdata) begin
                    w_par_waddr = AW'(r_rb);
                    w_par_wdata = r_ra;
                    n_res_root  = r_ra;
                end else begin
                    w_par_waddr = AW'(r_ra);
                    w_par_wdata = r_rb;
                    n_res_root  = r_rb;
                    if ((r_rank_a == w_rank_rdata) && (w_rank_rdata != RankMax)) begin
                        w_rank_wen   = 1'b1;
                        w_rank_waddr = AW'(r_rb);
                        w_rank_wdata = w_rank_rdata + RankW'(1);
                    end
                end
                n_state = ST_OUT;
            end

            // move the result into the output register once it is free
            ST_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_root  = r_res_root;
                    n_out_err   = r_res_err;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a walk (find or union operand) has reached its end
        if (w_fd) begin
            if (r_func == FN_FIND) begin
                n_res_root = w_fd_root;
                n_res_err  = 1'b0;
                n_state    = ST_OUT;
            end else if (!r_phase_b) begin
                n_ra      = w_fd_root;
                n_phase_b = 1'b1;
                n_x       = r_b;
                n_cur     = r_b;
                n_steps   = '0;
                n_state   = ST_WALK_RD;
            end else if (w_fd_root == r_ra) begin
                n_res_root = r_ra;
                n_res_err  = 1'b0;
                n_state    = ST_OUT;
            end else begin
                n_rb    = w_fd_root;
                n_state = ST_RANK_A;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_eiu       <= EiuReset;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wen) begin
                r_eiu <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_phase_b  <= n_phase_b;
        r_b        <= n_b;
        r_x        <= n_x;
        r_cur      <= n_cur;
        r_root     <= n_root;
        r_ra       <= n_ra;
        r_rb       <= n_rb;
        r_rank_a   <= n_rank_a;
        r_steps    <= n_steps;
        r_res_root <= n_res_root;
        r_res_err  <= n_res_err;
        r_out_root <= n_out_root;
        r_out_err  <= n_out_err;
    end

    // result channel
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(16-ElemW){1'b0}}, r_out_root};
    assign o_m_tuser  = r_out_err;

`ifndef SYNTHESIS
    // one request in flight: ready drops right after an accept
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire |=> !o_s_tready)
        else $error("request accepted while another is in flight");

    // a rejected request reports root zero
    a_error_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("error result with non-zero root");

    // walk counter stays below the store depth
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WALK_CHK) || (r_state == ST_CMP_WR))
            |-> (32'(r_steps) < 32'(MAX_ELEMENTS)))
        else $error("walk step count beyond store depth");
`endif

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// union-find engine testbench
// Drives makeset, find and union requests into union_find_engine_unit and
// checks every result against a bench mirror of the parent and rank stores
// or its row's value. A directed table comes first, covering range edges,
// the unknown operation code, same-set unions and the zero-element limit.
// Random phases follow, each under its own element limit, with random
// gaps on the request side and random back-pressure on the result side.
// ----------------------------------------------------------------------------
module testbench
    import ufe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // operation code with no operation behind it
    localparam logic [FuncW-1:0] FnUnknown = 2'd3;

    typedef struct packed {
        logic [ElemW-1:0] root;
        logic             err_flag;
    } t_uf_result;

    typedef struct packed {
        bit               is_cfg;
        logic [EiuW-1:0]  cfg_value;
        logic [FuncW-1:0] func;
        logic [ElemW-1:0] elem_a;
        logic [ElemW-1:0] elem_b;
        bit               typed;
        t_uf_result       want;
    } t_plan_row;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [23:0]      s_tdata   = '0;   // [9:0] elem_a, [19:10] elem_b, zero pad
    logic [FuncW-1:0] s_tuser   = '0;   // [1:0] func
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [15:0]      m_tdata;          // [9:0] root, zero pad
    logic             m_tuser;          // [0] error
    logic             cfg_wen   = 1'b0;
    logic [EiuW-1:0]  cfg_wdata = '0;

    // mirror of the forest and the element limit
    logic [ElemW-1:0] parent_mirror [MaxElementsDef];
    logic [RankW-1:0] rank_mirror   [MaxElementsDef];
    bit               made_mirror   [MaxElementsDef];
    logic [EiuW-1:0]  limit_mirror  = EiuReset;

    t_uf_result       pending_results [$];
    t_plan_row        directed_plan   [$];
    logic [ElemW-1:0] elem_pool       [$];
    int               mismatch_count  = 0;
    bit               quiet_run       = 1'b0;

    union_find_engine_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_wen  (cfg_wen),
        .i_cfg_wdata(cfg_wdata)
    );

    // clock, 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_run) return 0;
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic bit in_range(logic [ElemW-1:0] idx);
        return {1'b0, idx} < limit_mirror;
    endfunction

    // walk to the root, then point the whole path at it
    function automatic logic [ElemW-1:0] trace_root(logic [ElemW-1:0] x);
        logic [ElemW-1:0] r;
        logic [ElemW-1:0] n;
        logic [ElemW-1:0] p;
        int steps;
        r = x;
        steps = 0;
        while (steps < MaxElementsDef && parent_mirror[r] != r) begin
            r = parent_mirror[r];
            steps++;
        end
        n = x;
        steps = 0;
        while (n != r && steps < MaxElementsDef) begin
            p = parent_mirror[n];
            parent_mirror[n] = r;
            n = p;
            steps++;
        end
        return r;
    endfunction

    // apply one request to the mirror and return its result
    function automatic t_uf_result forest_update(logic [FuncW-1:0] f,
                                                 logic [ElemW-1:0] a,
                                                 logic [ElemW-1:0] b);
        t_uf_result res;
        logic [ElemW-1:0] ra;
        logic [ElemW-1:0] rb;
        res = '0;
        case (f)
            FN_MAKESET: begin
                if (in_range(a)) begin
                    parent_mirror[a] = a;
                    rank_mirror[a] = '0;
                    made_mirror[a] = 1'b1;
                    res.root = a;
                end else begin
                    res.err_flag = 1'b1;
                end
            end
            FN_FIND: begin
                if (in_range(a)) res.root = trace_root(a);
                else res.err_flag = 1'b1;
            end
            FN_UNION: begin
                if (in_range(a) && in_range(b)) begin
                    ra = trace_root(a);
                    rb = trace_root(b);
                    if (ra == rb) begin
                        res.root = ra;
                    end else if (rank_mirror[ra] > rank_mirror[rb]) begin
                        parent_mirror[rb] = ra;
                        res.root = ra;
                    end else begin
                        // equal ranks: second root wins and grows, saturating
                        parent_mirror[ra] = rb;
                        if (rank_mirror[ra] == rank_mirror[rb] && rank_mirror[rb] < RankMax)
                            rank_mirror[rb] = rank_mirror[rb] + 1'b1;
                        res.root = rb;
                    end
                end else begin
                    res.err_flag = 1'b1;
                end
            end
            default: res.err_flag = 1'b1;
        endcase
        return res;
    endfunction

    // present one request and wait for it to be taken
    task automatic send_request(input logic [FuncW-1:0] f, input logic [ElemW-1:0] a,
                                input logic [ElemW-1:0] b, input bit typed,
                                input t_uf_result want);
        int gap;
        t_uf_result predicted;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, b, a};
        s_tuser  <= f;
        do @(posedge clk); while (!s_tready);
        predicted = forest_update(f, a, b);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // register write, only with the engine idle
    task automatic write_limit(input logic [EiuW-1:0] value);
        drop_valid();
        wait_results_drained();
        repeat (4) @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        limit_mirror = value;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic add_req(input logic [FuncW-1:0] f, input logic [ElemW-1:0] a,
                           input logic [ElemW-1:0] b);
        directed_plan.push_back('{1'b0, '0, f, a, b, 1'b0, '0});
    endtask

    task automatic add_req_exp(input logic [FuncW-1:0] f, input logic [ElemW-1:0] a,
                               input logic [ElemW-1:0] b, input logic [ElemW-1:0] root,
                               input logic err);
        directed_plan.push_back('{1'b0, '0, f, a, b, 1'b1, '{root, err}});
    endtask

    task automatic add_cfg(input logic [EiuW-1:0] value);
        directed_plan.push_back('{1'b1, value, '0, '0, '0, 1'b0, '0});
    endtask

    // pick a pool element that makeset has already written
    function automatic bit pick_made(output logic [ElemW-1:0] idx);
        logic [ElemW-1:0] c;
        idx = '0;
        for (int t = 0; t < 8; t++) begin
            c = elem_pool[$urandom_range(0, elem_pool.size() - 1)];
            if (made_mirror[c]) begin
                idx = c;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // one random phase under one element limit
    task automatic run_random_phase(input logic [EiuW-1:0] limit, input int count);
        int lim;
        int r;
        logic [FuncW-1:0] f;
        logic [ElemW-1:0] a;
        logic [ElemW-1:0] b;
        logic [ElemW-1:0] good;
        logic [ElemW-1:0] bad;
        write_limit(limit);
        lim = (limit > MaxElementsDef) ? MaxElementsDef : int'(limit);
        elem_pool.delete();
        if (lim > 0) begin
            elem_pool.push_back('0);
            elem_pool.push_back(ElemW'(lim - 1));
            repeat ($urandom_range(6, 38)) elem_pool.push_back(ElemW'($urandom_range(0, lim - 1)));
        end
        for (int k = 0; k < count; k++) begin
            quiet_run = (k < 25);
            // sender holds off until everything outstanding is back
            if (k == count / 2) begin
                drop_valid();
                wait_results_drained();
            end
            r = $urandom_range(0, 99);
            b = ElemW'($urandom);
            if (elem_pool.size() == 0) begin
                f = FuncW'($urandom_range(0, 3));
                a = ElemW'($urandom);
            end else if (r < 20) begin
                f = FN_MAKESET;
                a = elem_pool[$urandom_range(0, elem_pool.size() - 1)];
                for (int t = 0; t < 4 && made_mirror[a]; t++)
                    a = elem_pool[$urandom_range(0, elem_pool.size() - 1)];
            end else if (r < 45) begin
                f = FN_FIND;
                if (!pick_made(a)) begin
                    f = FN_MAKESET;
                    a = elem_pool[$urandom_range(0, elem_pool.size() - 1)];
                end
            end else if (r < 85) begin
                f = FN_UNION;
                if (!(pick_made(a) && pick_made(b))) begin
                    f = FN_MAKESET;
                    a = elem_pool[$urandom_range(0, elem_pool.size() - 1)];
                end
            end else if (r < 93 && lim < MaxElementsDef) begin
                // out-of-range index, never a read of an unwritten entry
                f = FuncW'($urandom_range(0, 2));
                bad = ElemW'($urandom_range(lim, MaxElementsDef - 1));
                a = bad;
                if (f == FN_UNION) begin
                    if (!pick_made(good)) good = ElemW'($urandom_range(lim, MaxElementsDef - 1));
                    if ($urandom_range(0, 1) == 0) b = good;
                    else begin
                        a = good;
                        b = bad;
                    end
                end
            end else begin
                f = FnUnknown;
                a = ElemW'($urandom);
            end
            send_request(f, a, b, 1'b0, '0);
        end
        quiet_run = 1'b0;
    endtask

    // result side back-pressure
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // compare each result with the oldest expectation
    always @(posedge clk) begin : result_check
        t_uf_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[ElemW-1:0] !== want.root)
                    report_mismatch($sformatf("root %0d, predicted %0d",
                                              m_tdata[ElemW-1:0], want.root));
                if (m_tuser !== want.err_flag)
                    report_mismatch($sformatf("error flag %b, predicted %b",
                                              m_tuser, want.err_flag));
            end
        end
    end

    // main sequence
    initial begin
        // directed table, reset limit of 1024 to start with
        add_req_exp(FN_MAKESET, 10'd0, 10'd1023, 10'd0, 1'b0);
        add_req_exp(FN_MAKESET, 10'd1023, 10'd0, 10'd1023, 1'b0);
        add_req_exp(FN_MAKESET, 10'd5, 10'd0, 10'd5, 1'b0);
        add_req_exp(FN_MAKESET, 10'd6, 10'd0, 10'd6, 1'b0);
        add_req_exp(FN_FIND, 10'd1023, 10'd1023, 10'd1023, 1'b0);
        add_req_exp(FN_UNION, 10'd5, 10'd6, 10'd6, 1'b0);
        add_req_exp(FN_UNION, 10'd0, 10'd1023, 10'd1023, 1'b0);
        add_req(FN_UNION, 10'd5, 10'd1023);
        add_req(FN_FIND, 10'd5, 10'd0);
        add_req(FN_UNION, 10'd6, 10'd0);
        add_req_exp(FnUnknown, 10'd1023, 10'd1023, 10'd0, 1'b1);
        // only element 0 valid
        add_cfg(11'd1);
        add_req_exp(FN_MAKESET, 10'd0, 10'd1023, 10'd0, 1'b0);
        add_req_exp(FN_MAKESET, 10'd1, 10'd0, 10'd0, 1'b1);
        add_req_exp(FN_FIND, 10'd1023, 10'd0, 10'd0, 1'b1);
        add_req_exp(FN_UNION, 10'd0, 10'd1, 10'd0, 1'b1);
        add_req_exp(FN_UNION, 10'd1023, 10'd0, 10'd0, 1'b1);
        add_req_exp(FN_FIND, 10'd0, 10'd1023, 10'd0, 1'b0);
        // zero elements: everything rejected
        add_cfg(11'd0);
        add_req_exp(FN_MAKESET, 10'd0, 10'd0, 10'd0, 1'b1);
        add_req_exp(FN_FIND, 10'd0, 10'd0, 10'd0, 1'b1);
        add_req_exp(FN_UNION, 10'd0, 10'd0, 10'd0, 1'b1);
        // limit above the store depth
        add_cfg(11'd2047);
        add_req(FN_FIND, 10'd5, 10'd1023);
        add_req(FN_UNION, 10'd1023, 10'd1023);
        add_req_exp(FN_MAKESET, 10'd1023, 10'd5, 10'd1023, 1'b0);
        add_cfg(EiuReset);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg)
                write_limit(directed_plan[i].cfg_value);
            else
                send_request(directed_plan[i].func, directed_plan[i].elem_a,
                             directed_plan[i].elem_b, directed_plan[i].typed,
                             directed_plan[i].want);
        end

        run_random_phase(EiuReset, 130);
        run_random_phase(11'd2047, 130);
        run_random_phase(11'd1, 30);
        run_random_phase(11'd0, 30);
        run_random_phase(EiuW'($urandom_range(2, 64)), 130);
        run_random_phase(EiuW'($urandom_range(65, 1023)), 130);
        run_random_phase(EiuW'($urandom_range(1025, 2047)), 130);
        run_random_phase(EiuReset, 130);

        drop_valid();
        wait_results_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop, several times the slowest legal run
    initial begin
        #12_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
